// ===== rtl/core/cursor_linked_list_assert.svh =====
// Assertion macros shared by the cursor linked list RTL.
`ifndef CURSOR_LINKED_LIST_ASSERT_SVH
`define CURSOR_LINKED_LIST_ASSERT_SVH

// Clocked assertion that is switched off while reset is applied.
`define CLL_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cursor_linked_list: assertion failed");

// Clocked assertion that also holds during reset.
`define CLL_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("cursor_linked_list: assertion failed");

`endif

// ===== rtl/core/cll_pkg.sv =====
// Package with shared types, codes and constants of the cursor linked list.
`timescale 1ns / 1ps
package cll_pkg;

  // Default node count and fixed field widths.
  localparam int unsigned NODES_DEF = 64;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned IDX_W     = 6;

  // Command codes carried by an input beat.
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_CLR_START,
    OP_SWEEP,
    OP_INS,
    OP_STEP,
    OP_UNLINK_HEAD,
    OP_UNLINK_PREV,
    OP_FREE
  } dp_op_e;

  // Updates of the pending result.
  typedef enum logic [1:0] {
    RES_NONE,
    RES_HIT,
    RES_MISS,
    RES_CLEAR
  } res_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    dp_op_e op;
    res_e   res;
    logic   out_load;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cur_zero;
    logic prev_zero;
    logic match;
    logic full;
    logic sweep_last;
  } status_t;

endpackage

// ===== rtl/core/cll_if.sv =====
// Command and response channel interfaces of the cursor linked list.
`timescale 1ns / 1ps
interface cll_cmd_if;
  import cll_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

interface cll_rsp_if;
  import cll_pkg::*;

  logic             valid;
  logic             ready;
  logic             ok;
  logic [IDX_W-1:0] node_index;
  logic             is_empty;
  logic             is_full;

  modport source (output valid, output ok, output node_index, output is_empty,
                  output is_full, input ready);
  modport sink (input valid, input ok, input node_index, input is_empty,
                input is_full, output ready);
endinterface

// ===== rtl/core/cursor_linked_list.sv =====
// Top level of the array-backed linked list with a circular free chain.
//
//   channel  direction  beat contents
//   cmd_i    in         command, value
//   rsp_o    out        ok, node_index, is_empty, is_full
//
// Insert takes the node at the head of the free chain. Search and delete walk
// the valid chain one node per step, and a delete through a predecessor frees
// the node in an extra step; each link costs one read of the node memory.
// Clear writes one link per cycle, and after reset a sweep lays out the links
// before a command beat is taken. One command is in work at a time; the
// result register lets the next one start while rsp_o stalls.
`timescale 1ns / 1ps
`include "cursor_linked_list_assert.svh"
module cursor_linked_list #(
  parameter int unsigned NODES = cll_pkg::NODES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cll_cmd_if.sink       cmd_i,
  cll_rsp_if.source     rsp_o
);
  import cll_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  // Command sequencing.
  cll_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .command_i   (cmd_i.command),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  // Node storage and pointers.
  cll_dpath #(
    .NODES (NODES)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .command_i    (cmd_i.command),
    .value_i      (cmd_i.value),
    .ctrl_i       (ctrl),
    .status_o     (status),
    .ok_o         (rsp_o.ok),
    .node_index_o (rsp_o.node_index),
    .is_empty_o   (rsp_o.is_empty),
    .is_full_o    (rsp_o.is_full)
  );

  // A command beat is never followed directly by another one.
  `CLL_ASSERT(a_one_cmd, clk_i, rst_ni, (cmd_i.valid && cmd_i.ready) |=> !cmd_i.ready)

  // The node pool is never empty on both chains at once.
  `CLL_ASSERT(a_not_empty_and_full, clk_i, rst_ni,
    rsp_o.valid |-> !(rsp_o.is_empty && rsp_o.is_full))

  // A failed command reports node zero.
  `CLL_ASSERT(a_miss_index, clk_i, rst_ni, (rsp_o.valid && !rsp_o.ok) |-> (rsp_o.node_index == '0))

  // A load into the result register only happens while no result is held
  // or the held one is being taken.
  `CLL_ASSERT(a_no_overwrite, clk_i, rst_ni,
    ctrl.out_load |-> (!rsp_o.valid || rsp_o.ready))

endmodule

// ===== rtl/core/cll_ctrl.sv =====
// Controller state machine that sequences list commands over the datapath.
`timescale 1ns / 1ps
module cll_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [cll_pkg::CMD_W-1:0] command_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  cll_pkg::status_t       status_i,
  output cll_pkg::ctrl_t         ctrl_o
);
  import cll_pkg::*;

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_INS      = 3'd2;
  localparam logic [2:0] S_WALK     = 3'd3;
  localparam logic [2:0] S_DEL_FREE = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [2:0] state_q, state_d;
  logic       is_del_q, is_del_d;
  logic       clr_cmd_q, clr_cmd_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  // The output register can take a new result when empty or being drained.
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state and datapath commands.
  always_comb begin
    state_d         = state_q;
    is_del_d        = is_del_q;
    clr_cmd_d       = clr_cmd_q;
    in_ready_o      = 1'b0;
    ctrl_o.op       = OP_NONE;
    ctrl_o.res      = RES_NONE;
    ctrl_o.out_load = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        ctrl_o.op = OP_SWEEP;
        if (status_i.sweep_last) begin
          ctrl_o.res = RES_CLEAR;
          state_d    = clr_cmd_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (cmd_e'(command_i))
            CMD_INSERT: begin
              ctrl_o.op = OP_ACCEPT;
              state_d   = S_INS;
            end
            CMD_SEARCH: begin
              ctrl_o.op = OP_ACCEPT;
              is_del_d  = 1'b0;
              state_d   = S_WALK;
            end
            CMD_DELETE: begin
              ctrl_o.op = OP_ACCEPT;
              is_del_d  = 1'b1;
              state_d   = S_WALK;
            end
            CMD_CLEAR: begin
              ctrl_o.op = OP_CLR_START;
              clr_cmd_d = 1'b1;
              state_d   = S_CLEAR;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_INS: begin
        if (status_i.full) begin
          ctrl_o.res = RES_MISS;
        end else begin
          ctrl_o.op  = OP_INS;
          ctrl_o.res = RES_HIT;
        end
        state_d = S_DONE;
      end
      S_WALK: begin
        priority if (status_i.cur_zero) begin
          ctrl_o.res = RES_MISS;
          state_d    = S_DONE;
        end else if (status_i.match) begin
          ctrl_o.res = RES_HIT;
          priority if (!is_del_q) begin
            state_d = S_DONE;
          end else if (status_i.prev_zero) begin
            ctrl_o.op = OP_UNLINK_HEAD;
            state_d   = S_DONE;
          end else begin
            ctrl_o.op = OP_UNLINK_PREV;
            state_d   = S_DEL_FREE;
          end
        end else begin
          ctrl_o.op = OP_STEP;
        end
      end
      S_DEL_FREE: begin
        ctrl_o.op = OP_FREE;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          ctrl_o.out_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output valid flag of the result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // State registers; reset starts the link layout sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      is_del_q    <= 1'b0;
      clr_cmd_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      is_del_q    <= is_del_d;
      clr_cmd_q   <= clr_cmd_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/cll_dpath.sv =====
// Datapath with node memories, chain pointers and the result register.
`timescale 1ns / 1ps
module cll_dpath #(
  parameter int unsigned NODES = cll_pkg::NODES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [cll_pkg::CMD_W-1:0]     command_i,
  input  logic signed [cll_pkg::VAL_W-1:0] value_i,
  input  cll_pkg::ctrl_t                ctrl_i,
  output cll_pkg::status_t              status_o,
  output logic                          ok_o,
  output logic [cll_pkg::IDX_W-1:0]     node_index_o,
  output logic                          is_empty_o,
  output logic                          is_full_o
);
  import cll_pkg::*;

  localparam int unsigned IW = $clog2(NODES);
  localparam logic [IW-1:0] NilIdx    = '0;
  localparam logic [IW-1:0] FreeHead  = IW'(1);
  localparam logic [IW-1:0] FirstFree = IW'(2);
  localparam logic [IW-1:0] LastIdx   = IW'(NODES - 1);

  // Node memories; the heads of both chains live in registers.
  logic [IW-1:0]    link_mem  [NODES];
  logic [VAL_W-1:0] value_mem [NODES];

  logic [IW-1:0]    head_q, head_d;
  logic [IW-1:0]    free_q, free_d;
  logic [IW-1:0]    cur_q, cur_d;
  logic [IW-1:0]    prev_q, prev_d;
  logic [VAL_W-1:0] key_q, key_d;
  logic [IW-1:0]    rd_link_q;
  logic [VAL_W-1:0] rd_value_q;
  logic             res_ok_q, res_ok_d;
  logic [IW-1:0]    res_idx_q, res_idx_d;
  logic             out_ok_q;
  logic [IW-1:0]    out_idx_q;
  logic             out_empty_q;
  logic             out_full_q;
  logic             link_we;
  logic [IW-1:0]    link_waddr;
  logic [IW-1:0]    link_wdata;
  logic             value_we;
  logic [IW-1:0]    cur_inc;

  assign cur_inc = cur_q + IW'(1);

  // Pointer updates and memory writes for each operation.
  always_comb begin
    head_d     = head_q;
    free_d     = free_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    key_d      = key_q;
    link_we    = 1'b0;
    link_waddr = cur_q;
    link_wdata = free_q;
    value_we   = 1'b0;
    unique case (ctrl_i.op)
      OP_NONE: begin
      end
      OP_ACCEPT: begin
        key_d  = value_i;
        prev_d = NilIdx;
        cur_d  = (cmd_e'(command_i) == CMD_INSERT) ? free_q : head_q;
      end
      OP_CLR_START: begin
        head_d = NilIdx;
        free_d = FirstFree;
        cur_d  = FirstFree;
      end
      OP_SWEEP: begin
        link_we    = 1'b1;
        link_wdata = (cur_q == LastIdx) ? FreeHead : cur_inc;
        cur_d      = cur_inc;
      end
      OP_INS: begin
        value_we   = 1'b1;
        link_we    = 1'b1;
        link_wdata = head_q;
        head_d     = cur_q;
        free_d     = rd_link_q;
      end
      OP_STEP: begin
        prev_d = cur_q;
        cur_d  = rd_link_q;
      end
      OP_UNLINK_HEAD: begin
        head_d  = rd_link_q;
        link_we = 1'b1;
        free_d  = cur_q;
      end
      OP_UNLINK_PREV: begin
        link_we    = 1'b1;
        link_waddr = prev_q;
        link_wdata = rd_link_q;
      end
      OP_FREE: begin
        link_we = 1'b1;
        free_d  = cur_q;
      end
      default: begin
      end
    endcase
  end

  // Pending result of the current command.
  always_comb begin
    res_ok_d  = res_ok_q;
    res_idx_d = res_idx_q;
    unique case (ctrl_i.res)
      RES_NONE: begin
      end
      RES_HIT: begin
        res_ok_d  = 1'b1;
        res_idx_d = cur_q;
      end
      RES_MISS: begin
        res_ok_d  = 1'b0;
        res_idx_d = NilIdx;
      end
      RES_CLEAR: begin
        res_ok_d  = 1'b1;
        res_idx_d = NilIdx;
      end
      default: begin
      end
    endcase
  end

  // Chain heads and sweep cursor; reset gives the layout a sweep expects.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= NilIdx;
      free_q <= FirstFree;
      cur_q  <= FirstFree;
    end else begin
      head_q <= head_d;
      free_q <= free_d;
      cur_q  <= cur_d;
    end
  end

  // Payload registers and the result register.
  always_ff @(posedge clk_i) begin
    prev_q    <= prev_d;
    key_q     <= key_d;
    res_ok_q  <= res_ok_d;
    res_idx_q <= res_idx_d;
    if (ctrl_i.out_load) begin
      out_ok_q    <= res_ok_q;
      out_idx_q   <= res_idx_q;
      out_empty_q <= (head_q == NilIdx);
      out_full_q  <= (free_q == FreeHead);
    end
  end

  // Node memories: one write port, one registered read at the next cursor.
  always_ff @(posedge clk_i) begin
    rd_link_q  <= link_mem[cur_d];
    rd_value_q <= value_mem[cur_d];
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (value_we) begin
      value_mem[cur_q] <= key_q;
    end
  end

  // Status toward the controller.
  assign status_o.cur_zero   = (cur_q == NilIdx);
  assign status_o.prev_zero  = (prev_q == NilIdx);
  assign status_o.match      = (rd_value_q == key_q);
  assign status_o.full       = (free_q == FreeHead);
  assign status_o.sweep_last = (cur_q == LastIdx);

  assign ok_o         = out_ok_q;
  assign node_index_o = IDX_W'(out_idx_q);
  assign is_empty_o   = out_empty_q;
  assign is_full_o    = out_full_q;

endmodule

// ===== test/cursor_linked_list_tb.sv =====
// Self-checking testbench for the cursor linked list with a shadow list model.
`timescale 1ns / 1ps
module cursor_linked_list_tb;
  import cll_pkg::*;

  localparam int unsigned NODES = cll_pkg::NODES_DEF;

  // One expected response beat.
  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] node_index;
    logic             is_empty;
    logic             is_full;
  } list_rsp_t;

  logic clk_i;
  logic rst_ni;

  cll_cmd_if cmd_if ();
  cll_rsp_if rsp_if ();

  cursor_linked_list #(
    .NODES(NODES)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .rsp_o (rsp_if)
  );

  // Shadow copy of the node array and its links.
  logic [VAL_W-1:0] shadow_value[NODES];
  int unsigned      shadow_link[NODES];

  list_rsp_t        pending_rsp[$];
  logic [VAL_W-1:0] key_pool[8];
  int unsigned      mismatches;
  bit               cmd_gaps_on;
  bit               rsp_stalls_on;

  // Free-running clock.
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Restores the reset layout: empty valid chain, nodes 2 to NODES-1 on the free chain.
  function automatic void shadow_layout();
    for (int unsigned i = 0; i < NODES; i++) begin
      shadow_link[i] = i + 1;
    end
    shadow_link[0]       = 0;
    shadow_link[NODES-1] = 1;
  endfunction

  // Applies one command to the shadow list and returns the response it causes.
  function automatic list_rsp_t list_step(cmd_e op, logic [VAL_W-1:0] key);
    list_rsp_t   r;
    int unsigned p;
    int unsigned q;
    int unsigned steps;
    bit          stop;
    r = '0;
    case (op)
      CMD_INSERT: begin
        p = shadow_link[1];
        if (p != 1 && p < NODES) begin
          shadow_link[1] = shadow_link[p];
          shadow_value[p] = key;
          shadow_link[p] = shadow_link[0];
          shadow_link[0] = p;
          r.ok = 1'b1;
          r.node_index = p[IDX_W-1:0];
        end
      end
      CMD_SEARCH: begin
        p = shadow_link[0];
        for (steps = 0; steps < NODES && !r.ok && p != 0 && p < NODES; steps++) begin
          if (shadow_value[p] == key) begin
            r.ok = 1'b1;
            r.node_index = p[IDX_W-1:0];
          end else begin
            p = shadow_link[p];
          end
        end
      end
      CMD_DELETE: begin
        p = 0;
        stop = 1'b0;
        for (steps = 0; steps < NODES && !stop; steps++) begin
          q = shadow_link[p];
          if (q == 0 || q >= NODES) begin
            stop = 1'b1;
          end else if (shadow_value[q] == key) begin
            // Unlink through the predecessor and push onto the free chain.
            shadow_link[p] = shadow_link[q];
            shadow_link[q] = shadow_link[1];
            shadow_link[1] = q;
            r.ok = 1'b1;
            r.node_index = q[IDX_W-1:0];
            stop = 1'b1;
          end else begin
            p = q;
          end
        end
      end
      default: begin
        shadow_layout();
        r.ok = 1'b1;
      end
    endcase
    r.is_empty = (shadow_link[0] == 0);
    r.is_full  = (shadow_link[1] == 1);
    return r;
  endfunction

  // Counts a mismatch and reports the first few of them.
  task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t ns: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endtask

  // Sends one command beat, with an optional gap before it, and records the
  // response it must cause once the beat is taken.
  task automatic send_cmd(cmd_e op, logic [VAL_W-1:0] key);
    if (cmd_gaps_on && $urandom_range(0, 4) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.command <= op;
    cmd_if.value   <= key;
    do @(posedge clk_i); while (!cmd_if.ready);
    pending_rsp.push_back(list_step(op, key));
  endtask

  // Waits until every expected response beat has been seen.
  task automatic drain_responses();
    cmd_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  // Mostly pool values, so that keys repeat and searches hit; the rest are
  // corner patterns or fully random words.
  function automatic logic [VAL_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return key_pool[$urandom_range(0, 7)];
      6: begin
        case ($urandom_range(0, 3))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Fills the key pool with fresh random values and one corner value.
  task automatic refresh_pool();
    for (int i = 0; i < 8; i++) begin
      key_pool[i] = $urandom();
    end
    key_pool[$urandom_range(0, 7)] = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h0;
  endtask

  // Empty list behavior, extreme values, duplicates, deletes at the head, in
  // the middle and at the tail, misses, and clear.
  task automatic test_directed();
    send_cmd(CMD_SEARCH, 32'h0000_0000);
    send_cmd(CMD_DELETE, 32'h0000_0005);
    send_cmd(CMD_CLEAR,  32'hFFFF_FFFF);
    send_cmd(CMD_INSERT, 32'h8000_0000);
    send_cmd(CMD_INSERT, 32'h7FFF_FFFF);
    send_cmd(CMD_INSERT, 32'h0000_0000);
    send_cmd(CMD_INSERT, 32'hFFFF_FFFF);
    send_cmd(CMD_INSERT, 32'h7FFF_FFFF);
    send_cmd(CMD_SEARCH, 32'h7FFF_FFFF);
    send_cmd(CMD_SEARCH, 32'h8000_0000);
    send_cmd(CMD_SEARCH, 32'h1234_5678);
    send_cmd(CMD_DELETE, 32'h7FFF_FFFF);
    send_cmd(CMD_DELETE, 32'h8000_0000);
    send_cmd(CMD_DELETE, 32'h0000_0000);
    send_cmd(CMD_DELETE, 32'h5555_5555);
    send_cmd(CMD_SEARCH, 32'h7FFF_FFFF);
    send_cmd(CMD_INSERT, 32'hAAAA_AAAA);
    send_cmd(CMD_INSERT, 32'h5555_5555);
    send_cmd(CMD_CLEAR,  32'h0000_0000);
    send_cmd(CMD_SEARCH, 32'hAAAA_AAAA);
    send_cmd(CMD_DELETE, 32'hFFFF_FFFF);
    send_cmd(CMD_INSERT, 32'h0000_0001);
    drain_responses();
  endtask

  // Fills the list until inserts are refused, then empties it again.
  task automatic test_fill_to_full();
    logic [VAL_W-1:0] stored[$];
    logic [VAL_W-1:0] key;
    int               pick;
    send_cmd(CMD_CLEAR, $urandom());
    for (int i = 0; i < NODES - 2; i++) begin
      key = $urandom();
      stored.push_back(key);
      send_cmd(CMD_INSERT, key);
    end
    // Two refused inserts and a search that walks the whole chain.
    send_cmd(CMD_INSERT, $urandom());
    send_cmd(CMD_INSERT, $urandom());
    send_cmd(CMD_SEARCH, stored[0]);
    send_cmd(CMD_SEARCH, ~stored[0]);
    // Delete in random order, which unlinks at every position.
    while (stored.size() != 0) begin
      pick = $urandom_range(0, stored.size() - 1);
      send_cmd(CMD_DELETE, stored[pick]);
      stored.delete(pick);
    end
    send_cmd(CMD_SEARCH, $urandom());
    drain_responses();
  endtask

  // Random command mix; the percentages set the share of inserts, searches
  // and deletes, and the rest are clears.
  task automatic test_mixed_traffic(int unsigned count, int unsigned ins_pct,
                                    int unsigned srch_pct, int unsigned del_pct);
    int unsigned roll;
    cmd_e        op;
    refresh_pool();
    for (int unsigned i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) begin
        op = CMD_INSERT;
      end else if (roll < ins_pct + srch_pct) begin
        op = CMD_SEARCH;
      end else if (roll < ins_pct + srch_pct + del_pct) begin
        op = CMD_DELETE;
      end else begin
        op = CMD_CLEAR;
      end
      send_cmd(op, pick_key());
    end
    drain_responses();
  endtask

  // Response ready with random stall bursts.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_stalls_on && $urandom_range(0, 7) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  // Compares each response beat with the oldest expectation.
  always @(posedge clk_i) begin : check_rsp
    list_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp.size() == 0) begin
        flag_mismatch("response with none expected", 0, 32'(rsp_if.node_index));
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_if.ok !== want.ok) begin
          flag_mismatch("ok", 32'(want.ok), 32'(rsp_if.ok));
        end
        if (rsp_if.node_index !== want.node_index) begin
          flag_mismatch("node_index", 32'(want.node_index), 32'(rsp_if.node_index));
        end
        if (rsp_if.is_empty !== want.is_empty) begin
          flag_mismatch("is_empty", 32'(want.is_empty), 32'(rsp_if.is_empty));
        end
        if (rsp_if.is_full !== want.is_full) begin
          flag_mismatch("is_full", 32'(want.is_full), 32'(rsp_if.is_full));
        end
      end
    end
  end

  // Main sequence: reset, then the tests in turn.
  initial begin
    mismatches     = 0;
    cmd_gaps_on    = 1'b1;
    rsp_stalls_on  = 1'b1;
    rst_ni         <= 1'b0;
    cmd_if.valid   <= 1'b0;
    cmd_if.command <= CMD_INSERT;
    cmd_if.value   <= '0;
    for (int unsigned i = 0; i < NODES; i++) begin
      shadow_value[i] = '0;
    end
    shadow_layout();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_fill_to_full();
    test_mixed_traffic(160, 60, 18, 20);
    cmd_gaps_on   = 1'b0;
    rsp_stalls_on = 1'b0;
    test_mixed_traffic(100, 40, 30, 28);
    cmd_gaps_on   = 1'b1;
    rsp_stalls_on = 1'b1;
    test_mixed_traffic(120, 30, 30, 38);
    test_mixed_traffic(100, 50, 25, 23);
    // Final stretch runs at full rate on both sides.
    cmd_gaps_on   = 1'b0;
    rsp_stalls_on = 1'b0;
    test_mixed_traffic(120, 45, 27, 26);

    repeat (2 * NODES + 10) @(posedge clk_i);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("PASS cursor_linked_list");
    end else begin
      $display("FAIL cursor_linked_list");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #2_000_000;
    $display("FAIL cursor_linked_list");
    $finish;
  end

endmodule
